>>> rtl/stable_argsort_engine_unit_assert.svh
// Assertion macros for the checker of the stable argsort engine.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef STABLE_ARGSORT_ENGINE_UNIT_ASSERT_SVH
`define STABLE_ARGSORT_ENGINE_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SAEU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("saeu check failed");

// Consequent must hold in the cycle after the antecedent.
`define SAEU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("saeu check failed");

`endif

>>> rtl/saeu_pkg.sv
// Shared constants and types of the stable argsort engine.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package saeu_pkg;

    // Capacity of one set and the most results emitted per set.
    localparam int DEPTH      = 32;
    localparam int RESULT_CAP = 32;

    // Field widths.
    localparam int VAL_W  = 32;
    localparam int OIDX_W = 5;

    // Derived widths.
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = $clog2(RESULT_CAP + 1);
    localparam int EMIT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Configuration port.
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = APB_AW - 2;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_DESCENDING = '0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic start_asc;
        logic start_desc;
        logic head;
        logic ptr_dec;
        logic ptr_inc;
        logic mark_run;
        logic next_run;
        logic emit;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic ptr_zero;
        logic run_match;
        logic at_hi;
        logic final_emit;
    } t_dp_status;

endpackage

>>> rtl/saeu_ctrl.sv
// Sequencing controller of the stable argsort engine: loading, run search and emission.
// Depends on saeu_pkg for the command and status types.
`timescale 1ns / 1ps

module saeu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_last,
    input  logic                 i_descending,
    input  saeu_pkg::t_dp_status i_status,
    output logic                 o_ready,
    output saeu_pkg::t_dp_cmd    o_cmd
);
    import saeu_pkg::*;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_START = 5'b00010,
        S_HEAD  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_desc, n_desc;

    // State and direction registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_desc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_desc  <= n_desc;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_desc  = r_desc;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                // The direction is sampled once per set, when emission begins.
                n_desc = i_descending;
                if (i_descending) begin
                    o_cmd.start_desc = 1'b1;
                    n_state          = S_HEAD;
                end else begin
                    o_cmd.start_asc = 1'b1;
                    n_state         = S_EMIT;
                end
            end
            S_HEAD: begin
                // Capture the value of the highest remaining run.
                o_cmd.head = 1'b1;
                if (i_status.ptr_zero) begin
                    o_cmd.mark_run = 1'b1;
                    n_state        = S_EMIT;
                end else begin
                    o_cmd.ptr_dec = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                // Walk down to the first element of the run of equal values.
                if (i_status.run_match) begin
                    if (i_status.ptr_zero) begin
                        o_cmd.mark_run = 1'b1;
                        n_state        = S_EMIT;
                    end else begin
                        o_cmd.ptr_dec = 1'b1;
                    end
                end else begin
                    o_cmd.ptr_inc  = 1'b1;
                    o_cmd.mark_run = 1'b1;
                    n_state        = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.final_emit) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_LOAD;
                    end else if (r_desc && i_status.at_hi) begin
                        o_cmd.next_run = 1'b1;
                        n_state        = S_HEAD;
                    end else begin
                        o_cmd.ptr_inc = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

>>> rtl/saeu_dp.sv
// Datapath of the stable argsort engine: insertion chain, read pointers and result register.
// Depends on saeu_pkg for widths, capacity and the command and status types.
`timescale 1ns / 1ps

module saeu_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  saeu_pkg::t_dp_cmd                  i_cmd,
    input  logic signed [saeu_pkg::VAL_W-1:0]  i_value,
    input  logic                               i_ready,
    output saeu_pkg::t_dp_status               o_status,
    output logic                               o_valid,
    output logic signed [saeu_pkg::VAL_W-1:0]  o_sorted_value,
    output logic        [saeu_pkg::OIDX_W-1:0] o_original_index,
    output logic                               o_last_res,
    output logic                               o_overflow
);
    import saeu_pkg::*;

    // Cell row, kept sorted ascending by value and then by load position.
    logic signed [VAL_W-1:0] r_cell_val [DEPTH];
    logic        [IDX_W-1:0] r_cell_idx [DEPTH];

    logic [CNT_W-1:0]  r_count;
    logic              r_dropped;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [IDX_W-1:0]  r_hi;
    logic [IDX_W-1:0]  r_run_lo;
    logic [EMIT_W-1:0] r_emitted;
    logic signed [VAL_W-1:0] r_run_val;

    logic [DEPTH-1:0]        w_ins;
    logic                    w_has_room;
    logic                    w_insert;
    logic [CNT_W-1:0]        w_top_cnt;
    logic [IDX_W-1:0]        w_top;
    logic [IDX_W-1:0]        w_run_below;
    logic [EMIT_W-1:0]       w_cap;
    logic                    w_final;
    logic signed [VAL_W-1:0] w_rd_val;
    logic [IDX_W-1:0]        w_rd_idx;

    assign w_has_room = (r_count < CNT_W'(DEPTH));
    assign w_insert   = i_cmd.load && w_has_room;

    // A cell takes part in the insertion when it is empty or holds a larger value.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ins[i] = (CNT_W'(i) >= r_count) || (r_cell_val[i] > i_value);
        end
    end

    // Each cell keeps, takes the new element, or takes its lower neighbour.
    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            if (w_ins[0]) begin
                r_cell_val[0] <= i_value;
                r_cell_idx[0] <= r_count[IDX_W-1:0];
            end
            for (int i = 1; i < DEPTH; i++) begin
                if (w_ins[i]) begin
                    if (!w_ins[i-1]) begin
                        r_cell_val[i] <= i_value;
                        r_cell_idx[i] <= r_count[IDX_W-1:0];
                    end else begin
                        r_cell_val[i] <= r_cell_val[i-1];
                        r_cell_idx[i] <= r_cell_idx[i-1];
                    end
                end
            end
        end
    end

    // Fill count and dropped flag of the current set.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.finish) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.load) begin
            if (w_has_room) begin
                r_count <= r_count + CNT_W'(1);
            end else begin
                r_dropped <= 1'b1;
            end
        end
    end

    // Single read port of the cell row.
    assign w_rd_val = r_cell_val[r_ptr];
    assign w_rd_idx = r_cell_idx[r_ptr];

    assign w_top_cnt   = r_count - CNT_W'(1);
    assign w_top       = w_top_cnt[IDX_W-1:0];
    assign w_run_below = r_run_lo - IDX_W'(1);

    // Read pointer update.
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.start_asc) begin
            n_ptr = '0;
        end else if (i_cmd.start_desc) begin
            n_ptr = w_top;
        end else if (i_cmd.next_run) begin
            n_ptr = w_run_below;
        end else if (i_cmd.ptr_dec) begin
            n_ptr = r_ptr - IDX_W'(1);
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + IDX_W'(1);
        end
    end

    // Pointers, run bounds and the emitted count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr     <= '0;
            r_hi      <= '0;
            r_run_lo  <= '0;
            r_emitted <= '0;
        end else begin
            r_ptr <= n_ptr;
            if (i_cmd.start_desc) begin
                r_hi <= w_top;
            end else if (i_cmd.next_run) begin
                r_hi <= w_run_below;
            end
            if (i_cmd.mark_run) begin
                r_run_lo <= n_ptr;
            end
            if (i_cmd.start_asc || i_cmd.start_desc) begin
                r_emitted <= '0;
            end else if (i_cmd.emit) begin
                r_emitted <= r_emitted + EMIT_W'(1);
            end
        end
    end

    // Value of the run being searched.
    always_ff @(posedge i_clk) begin
        if (i_cmd.head) begin
            r_run_val <= w_rd_val;
        end
    end

    // Number of results this set emits.
    assign w_cap   = (EMIT_W'(r_count) > EMIT_W'(RESULT_CAP)) ? EMIT_W'(RESULT_CAP)
                                                              : EMIT_W'(r_count);
    assign w_final = ((r_emitted + EMIT_W'(1)) == w_cap);

    // Result register: control bit with reset, payload without.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_sorted_value   <= w_rd_val;
            o_original_index <= OIDX_W'(w_rd_idx);
            o_last_res       <= w_final;
            o_overflow       <= r_dropped;
        end
    end

    // Status to the controller.
    always_comb begin
        o_status.out_free   = !o_valid || i_ready;
        o_status.ptr_zero   = (r_ptr == '0);
        o_status.run_match  = (w_rd_val == r_run_val);
        o_status.at_hi      = (r_ptr == r_hi);
        o_status.final_emit = w_final;
    end

endmodule

>>> rtl/stable_argsort_engine_unit.sv
// Ready stays high throughout loading, so items are accepted back to back. After the last
// item the controller passes a start state and, in descending order, head and scan states
// that find the top run. Ascending emission gives one result per cycle while the receiver
// takes them; descending walks each run of equal values down and emits it upward, as every
// step goes through the single read port of the sorted cell row. Reset (synchronous, active
// low) empties the set, clears the overflow flag and result valid bit, selects ascending.
`timescale 1ns / 1ps

module stable_argsort_engine_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [saeu_pkg::VAL_W-1:0]     i_value,
    input  logic                                  i_last,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [saeu_pkg::VAL_W-1:0]     o_sorted_value,
    output logic        [saeu_pkg::OIDX_W-1:0]    o_original_index,
    output logic                                  o_last_res,
    output logic                                  o_overflow,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic        [saeu_pkg::APB_AW-1:0]    paddr,
    input  logic        [saeu_pkg::APB_DW-1:0]    pwdata,
    output logic        [saeu_pkg::APB_DW-1:0]    prdata,
    output logic                                  pready
);
    import saeu_pkg::*;

    logic                 r_descending;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_cfg_write;
    t_dp_cmd              w_cmd;
    t_dp_status           w_status;

    // Configuration register access.
    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[APB_AW-1:2];
    assign w_cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending <= 1'b0;
        end else if (w_cfg_write && (w_reg_idx == REG_DESCENDING)) begin
            r_descending <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_reg_idx == REG_DESCENDING) begin
            prdata[0] = r_descending;
        end
    end

    // Controller.
    saeu_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_last       (i_last),
        .i_descending (r_descending),
        .i_status     (w_status),
        .o_ready      (o_ready),
        .o_cmd        (w_cmd)
    );

    // Datapath.
    saeu_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_value          (i_value),
        .i_ready          (i_ready),
        .o_status         (w_status),
        .o_valid          (o_valid),
        .o_sorted_value   (o_sorted_value),
        .o_original_index (o_original_index),
        .o_last_res       (o_last_res),
        .o_overflow       (o_overflow)
    );

endmodule

>>> rtl/saeu_checker.sv
// Port-level checker of the stable argsort engine, bound to the top level.
// Depends on saeu_pkg for widths and on the shared assertion macro header.
`timescale 1ns / 1ps
`include "stable_argsort_engine_unit_assert.svh"

module saeu_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               i_last,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic signed [saeu_pkg::VAL_W-1:0]  o_sorted_value,
    input logic        [saeu_pkg::OIDX_W-1:0] o_original_index,
    input logic                               o_last_res,
    input logic                               o_overflow
);

    // Once the last item of a set is transferred, loading pauses for emission.
    `SAEU_ASSERT_NEXT(a_stop_after_last, i_clk, i_rst_n, i_valid && o_ready && i_last, !o_ready)

    // A result other than the final one means emission is still running.
    `SAEU_ASSERT_SAME(a_no_load_mid_set, i_clk, i_rst_n, o_valid && !o_last_res, !o_ready)

    // Every result of one set carries the same overflow flag.
    `SAEU_ASSERT_NEXT(a_overflow_steady, i_clk, i_rst_n, o_valid && !o_last_res, !o_valid || (o_overflow == $past(o_overflow)))

    // A stalled result holds its payload.
    `SAEU_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_sorted_value) && $stable(o_original_index))

endmodule

bind stable_argsort_engine_unit saeu_checker u_saeu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .i_last           (i_last),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_sorted_value   (o_sorted_value),
    .o_original_index (o_original_index),
    .o_last_res       (o_last_res),
    .o_overflow       (o_overflow)
);

>>> test/tb.sv
// Self-checking testbench for the stable argsort engine: sends sets of Q16.16 values and
// compares each sorted result with an in-bench stable sort of the same set.
// Depends on saeu_pkg and the stable_argsort_engine_unit top level.
`timescale 1ns / 1ps

module tb;
    import saeu_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_ITEMS  = 30;

    localparam logic [APB_AW-1:0] DESC_ADDR = {REG_DESCENDING, 2'b00};

    typedef logic signed [VAL_W-1:0] t_q16;

    localparam t_q16 Q_MIN = 32'sh8000_0000;
    localparam t_q16 Q_MAX = 32'sh7FFF_FFFF;
    localparam t_q16 Q_ONE = 32'sh0001_0000;

    typedef struct packed {
        logic [VAL_W-1:0]  value;
        logic [OIDX_W-1:0] index;
        logic              last;
        logic              overflow;
    } t_sorted_entry;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic signed [VAL_W-1:0]  i_value;
    logic                     i_last;
    logic                     o_valid;
    logic                     i_ready;
    logic signed [VAL_W-1:0]  o_sorted_value;
    logic [OIDX_W-1:0]        o_original_index;
    logic                     o_last_res;
    logic                     o_overflow;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_AW-1:0]        paddr;
    logic [APB_DW-1:0]        pwdata;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    // Expected sorted results, oldest first, and the set being loaded.
    t_sorted_entry sorted_q[$];
    t_q16          held_vals[$];
    bit            held_dropped;
    bit            desc_mode;

    t_q16 pending_set[$];
    int   fail_count;
    int   items_sent;
    bit   idle_on;
    bit   hold_request;

    stable_argsort_engine_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_value          (i_value),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_sorted_value   (o_sorted_value),
        .o_original_index (o_original_index),
        .o_last_res       (o_last_res),
        .o_overflow       (o_overflow),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog for a run that hangs.
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(string what, logic [31:0] wanted, logic [31:0] seen);
        $display("Mismatch on %s at %0t ns: expected %h, got %h", what, $realtime, wanted, seen);
        fail_count++;
    endtask

    // Mostly short idle spells, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 8);
        return $urandom_range(10, 40);
    endfunction

    // Element a is emitted ahead of element b; ties go to the lower position.
    function automatic bit precedes(t_q16 va, int ia, t_q16 vb, int ib);
        if (va != vb) return desc_mode ? (va > vb) : (va < vb);
        return ia < ib;
    endfunction

    // Loads one element into the mirrored set; on the last one, sorts and queues the results.
    function automatic void absorb_item(t_q16 v, bit last);
        t_q16          sv[DEPTH];
        int            si[DEPTH];
        int            j;
        int            n;
        int            emit;
        t_sorted_entry e;
        if (held_vals.size() < DEPTH) held_vals.push_back(v);
        else held_dropped = 1'b1;
        if (!last) return;
        n = held_vals.size();
        for (int i = 0; i < n; i++) begin
            j = i;
            while (j > 0 && precedes(held_vals[i], i, sv[j-1], si[j-1])) begin
                sv[j] = sv[j-1];
                si[j] = si[j-1];
                j--;
            end
            sv[j] = held_vals[i];
            si[j] = i;
        end
        emit = (n < RESULT_CAP) ? n : RESULT_CAP;
        for (int i = 0; i < emit; i++) begin
            e.value    = sv[i];
            e.index    = OIDX_W'(si[i]);
            e.last     = (i == emit - 1);
            e.overflow = held_dropped;
            sorted_q.push_back(e);
        end
        held_vals.delete();
        held_dropped = 1'b0;
    endfunction

    // Offers one element and waits for its transfer; valid is left high for the caller.
    task automatic send_item(t_q16 v, bit last);
        int gap;
        gap = (idle_on && $urandom_range(0, 1) == 1) ? idle_length() : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        i_last  <= last;
        do @(posedge i_clk); while (!o_ready);
        absorb_item(v, last);
        items_sent++;
    endtask

    task automatic send_set();
        foreach (pending_set[k]) send_item(pending_set[k], k == pending_set.size() - 1);
    endtask

    // Stops offering and waits until every expected result has come and the block is quiet.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the order register, then reads it back.
    task automatic set_sort_order(bit desc);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DESC_ADDR;
        pwdata  <= APB_DW'(desc);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        desc_mode = desc;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== APB_DW'(desc))
            report_mismatch("order register read", APB_DW'(desc), prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_q16 rand_value(int style);
        case (style)
            0: return $urandom;
            1: return (t_q16'($urandom_range(0, 6)) - 3) * Q_ONE;
            default: begin
                case ($urandom_range(0, 4))
                    0: return Q_MIN;
                    1: return Q_MAX;
                    2: return '0;
                    3: return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    function automatic void build_random_set(int size);
        int style;
        style = $urandom_range(0, 2);
        pending_set.delete();
        repeat (size) pending_set.push_back(rand_value(style));
    endfunction

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = idle_length() - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Result checker: each transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_sorted_entry want;
        if (i_rst_n && o_valid && i_ready) begin
            if (sorted_q.size() == 0) begin
                report_mismatch("result with none expected", '0, o_sorted_value);
            end else begin
                want = sorted_q.pop_front();
                if (o_sorted_value !== want.value)
                    report_mismatch("sorted_value", want.value, o_sorted_value);
                if (o_original_index !== want.index)
                    report_mismatch("original_index", 32'(want.index), 32'(o_original_index));
                if (o_last_res !== want.last)
                    report_mismatch("last_res", 32'(want.last), 32'(o_last_res));
                if (o_overflow !== want.overflow)
                    report_mismatch("overflow", 32'(want.overflow), 32'(o_overflow));
            end
        end
    end

    // Field extremes and ties in both directions, and a single-element set in ascending order.
    task automatic test_directed_sets();
        idle_on = 1'b1;
        pending_set = '{Q_MAX, Q_MIN, 0, -1, Q_ONE, Q_MIN};
        send_set();
        pending_set = '{Q_MIN};
        send_set();
        pending_set = '{5 * Q_ONE, 5 * Q_ONE, -3 * Q_ONE, 5 * Q_ONE, -3 * Q_ONE, 0};
        send_set();
        wait_for_drain();
        set_sort_order(1'b1);
        send_set();
        pending_set = '{Q_MAX, Q_MIN, 0, -1, Q_ONE, Q_MAX, 1};
        send_set();
        wait_for_drain();
    endtask

    // A full set, a final element that finds the set full, and drops before the last.
    task automatic test_overflow();
        set_sort_order(1'b0);
        build_random_set(DEPTH);
        send_set();
        build_random_set(DEPTH + 1);
        send_set();
        wait_for_drain();
        set_sort_order(1'b1);
        pending_set.delete();
        repeat (DEPTH + 4) pending_set.push_back(rand_value(1));
        send_set();
        wait_for_drain();
    endtask

    // The receiver holds off while two full sets are offered, so the input backs up.
    task automatic test_backpressure();
        idle_on      = 1'b0;
        hold_request = 1'b1;
        build_random_set(DEPTH);
        send_set();
        build_random_set(DEPTH);
        send_set();
        wait_for_drain();
        idle_on = 1'b1;
    endtask

    // Random sets, mostly small, in phases with the order changed in between.
    task automatic test_random();
        int start;
        int phase;
        int r;
        start = items_sent;
        phase = 0;
        while (items_sent - start < RANDOM_ITEMS) begin
            wait_for_drain();
            set_sort_order(phase == 0 ? 1'b0 : phase == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
            repeat ($urandom_range(2, 5)) begin
                r = $urandom_range(0, 99);
                if (r < 70) build_random_set($urandom_range(1, 8));
                else if (r < 92) build_random_set($urandom_range(9, DEPTH));
                else build_random_set($urandom_range(DEPTH + 1, DEPTH + 6));
                idle_on = ($urandom_range(0, 3) != 0);
                send_set();
            end
            phase++;
        end
        wait_for_drain();
    endtask

    // Reset, the test sequence and the verdict.
    initial begin
        fail_count   = 0;
        items_sent   = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        held_dropped = 1'b0;
        desc_mode    = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_value <= '0;
        i_last  <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_sets();
        test_overflow();
        test_backpressure();
        test_random();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
